FILE: design/lph_pkg.sv
// Shared types, codes and hash functions for the linear probe hash map.
// No dependencies; imported by linear_probe_hash_map.
package lph_pkg;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 64;
  localparam int LIMIT_W    = 11;
  localparam int START_W    = 11;
  localparam int SLOT_OUT_W = 10;
  localparam int LIVE_W     = 11;

  localparam logic [31:0]      KEY_EMPTY       = 32'hFFFF_FFFF;
  localparam logic [31:0]      KEY_TOMB        = 32'hFFFF_FFFE;
  localparam logic [VAL_W-1:0] VALUE_MINUS_ONE = 64'hBFF0_0000_0000_0000;

  localparam logic [LIMIT_W-1:0] FILL_RESET    = 11'd768;
  localparam logic [LIMIT_W-1:0] CLEANUP_RESET = 11'd256;

  localparam logic REG_FILL_LIMIT    = 1'b0;
  localparam logic REG_CLEANUP_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    FN_FIND, FN_GET, FN_ADD, FN_ADD_NEW, FN_ERASE, FN_CLEAR, FN_NEXT, FN_NONE
  } func_t;

  typedef enum logic [3:0] {
    RS_HIT, RS_INSERTED, RS_REPLACED, RS_ABSENT, RS_ERASED,
    RS_FULL, RS_CLEARED, RS_RECORD, RS_END
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_HASH1, ST_HASH2, ST_MOD, ST_PROBE, ST_SCAN, ST_EMIT,
    ST_CLEAR, ST_RH_CLR, ST_RH_RD, ST_RH_CHK, ST_RH_PRB
  } state_t;

  // First half of the integer hash mix.
  function automatic logic [31:0] jenkins_lo(input logic [31:0] x);
    logic [31:0] y;
    y = (x + 32'h7ed5_5d16) + (x << 12);
    y = (y ^ 32'hc761_c23c) ^ (y >> 19);
    y = (y + 32'h1656_67b1) + (y << 5);
    return y;
  endfunction

  // Second half of the integer hash mix.
  function automatic logic [31:0] jenkins_hi(input logic [31:0] x);
    logic [31:0] y;
    y = (x + 32'hd3a2_646c) ^ (x << 9);
    y = (y + 32'hfd70_46c5) + (y << 3);
    y = (y ^ 32'hb55a_4f09) ^ (y >> 16);
    return y;
  endfunction

endpackage

FILE: design/linear_probe_hash_map.sv
// Sequence: accept, hash states HASH1 and HASH2, reduce state MOD (byte by byte if CAPACITY
// is not a power of two), a probe per slot read from key memory, then EMIT loads the output.
// One operation at a time: a new operation is accepted only when the map is back in idle.
// Clear adds a sweep over every slot; a cleanup rehash adds a sweep of the other bank
// plus one read per slot and a hash, reduce and probe for each live record moved.
// Reset (rst_n low, synchronous): a clearing pass writes empty into both banks.
module linear_probe_hash_map import lph_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_func,
  input  logic [KEY_W-1:0]      in_lookup_key,
  input  logic [VAL_W-1:0]      in_new_value,
  input  logic [START_W-1:0]    in_start_slot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_status,
  output logic [KEY_W-1:0]      out_found_key,
  output logic [VAL_W-1:0]      out_found_value,
  output logic [SLOT_OUT_W-1:0] out_found_slot,
  output logic [LIVE_W-1:0]     out_live_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // slot index width
  localparam int CW = $clog2(CAPACITY + 1);                     // count width
  localparam int LW = (CW + 1 > LIMIT_W) ? CW + 1 : LIMIT_W;    // limit compare width
  localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
  localparam logic [SW:0]   CAP_EXT   = (SW + 1)'(CAPACITY);

  // Reduce one byte of the hash into the running remainder modulo CAPACITY.
  function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] r, input logic [7:0] b);
    logic [SW:0]   t;
    logic [SW-1:0] acc;
    acc = r;
    for (int k = 7; k >= 0; k--) begin
      t = {acc, b[k]};
      if (t >= CAP_EXT) t = t - CAP_EXT;
      acc = t[SW-1:0];
    end
    return acc;
  endfunction

  // Two banks of key and value memory; the active bank is bank_r.
  logic [31:0]      kmem [2][CAPACITY];
  logic [VAL_W-1:0] vmem [2][CAPACITY];
  logic [31:0]      kdata_r;
  logic [VAL_W-1:0] vdata_r;

  logic             rd_bank, wr_bank, kwe, vwe;
  logic [SW-1:0]    rd_slot, wr_slot;
  logic [31:0]      wr_key;
  logic [VAL_W-1:0] wr_val;

  // Control state.
  state_t             state_r, state_nxt, after_r, after_nxt;
  logic               bank_r, bank_nxt;
  logic [CW-1:0]      rc_r, rc_nxt, tc_r, tc_nxt;
  logic [LIMIT_W-1:0] fill_r, fill_nxt, clean_r, clean_nxt;
  logic [SW-1:0]      i_r, i_nxt;
  logic               ib_r, ib_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Operation payload.
  func_t            func_r, func_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] nval_r, nval_nxt, vhold_r, vhold_nxt;
  logic [31:0]      hkey_r, hkey_nxt, h_r, h_nxt;
  logic [SW-1:0]    rem_r, rem_nxt, j_r, j_nxt, pc_r, pc_nxt, fs_r, fs_nxt;
  logic [1:0]       mc_r, mc_nxt;
  logic             rh_r, rh_nxt, ff_r, ff_nxt, ft_r, ft_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [KEY_W-1:0] res_key_r, res_key_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [SW-1:0]    res_slot_r, res_slot_nxt;

  logic [3:0]            out_status_r, out_status_nxt;
  logic [KEY_W-1:0]      out_key_r, out_key_nxt;
  logic [VAL_W-1:0]      out_val_r, out_val_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [LIVE_W-1:0]     out_live_r, out_live_nxt;

  // Shared decode of the word just read from the key memory.
  logic          acc, emit_go, start_ok;
  logic [31:0]   key_ext;
  logic          k_hit, k_empty, k_tomb, k_live;
  logic [SW-1:0] j_step, i_step, rem_step, home;
  logic          i_last, pr_done, mod_done;
  logic          eff_ff, eff_ft, full, rh_go;
  logic [SW-1:0] eff_fs;
  logic [LW-1:0] used;
  logic [CW-1:0] tc_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign emit_go   = !out_valid_r || out_ready;
  assign start_ok  = 32'(in_start_slot) < 32'(CAPACITY);

  assign key_ext = {1'b0, key_r};
  assign k_hit   = (kdata_r == key_ext);
  assign k_empty = (kdata_r == KEY_EMPTY);
  assign k_tomb  = (kdata_r == KEY_TOMB);
  assign k_live  = !kdata_r[31];

  assign j_step  = (j_r == LAST_SLOT) ? '0 : j_r + 1'b1;
  assign i_last  = (i_r == LAST_SLOT);
  assign i_step  = i_last ? '0 : i_r + 1'b1;
  // A probe ends on a hit, on an empty slot, or after CAPACITY slots.
  assign pr_done = k_hit || k_empty || (pc_r == LAST_SLOT);

  // Home slot: mask for a power of two, else four byte steps of remainder.
  assign rem_step = mod_step(rem_r, h_r[31:24]);
  assign home     = POW2 ? h_r[SW-1:0] : rem_step;
  assign mod_done = POW2 || (mc_r == 2'd3);

  // First free slot on the path, counting the slot under examination.
  assign eff_ff = ff_r || k_empty || k_tomb;
  assign eff_fs = ff_r ? fs_r : j_r;
  assign eff_ft = ff_r ? ft_r : k_tomb;
  assign used   = LW'(rc_r) + LW'(tc_r) + LW'(!eff_ft);
  assign full   = !eff_ff || (used > LW'(fill_r));
  assign tc_inc = tc_r + 1'b1;
  assign rh_go  = LW'(tc_inc) >= LW'(clean_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (i_last && ib_r) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          unique case (func_t'(in_func))
            FN_FIND, FN_GET, FN_ADD, FN_ADD_NEW, FN_ERASE: state_nxt = ST_HASH1;
            FN_NEXT:                                     state_nxt = start_ok ? ST_SCAN : ST_EMIT;
            FN_CLEAR, FN_NONE:                           state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_HASH1:  state_nxt = ST_HASH2;
      ST_HASH2:  state_nxt = ST_MOD;
      ST_MOD:    if (mod_done) state_nxt = rh_r ? ST_RH_PRB : ST_PROBE;
      ST_PROBE:  if (pr_done) state_nxt = ST_EMIT;
      ST_SCAN:   if (k_live || j_r == LAST_SLOT) state_nxt = ST_EMIT;
      ST_EMIT:   if (emit_go) state_nxt = after_r;
      ST_CLEAR:  if (i_last) state_nxt = ST_IDLE;
      ST_RH_CLR: if (i_last) state_nxt = ST_RH_RD;
      ST_RH_RD:  state_nxt = ST_RH_CHK;
      ST_RH_CHK: begin
        if (k_live) state_nxt = ST_HASH1;
        else if (i_last) state_nxt = ST_IDLE;
      end
      ST_RH_PRB: if (k_empty) state_nxt = i_last ? ST_IDLE : ST_RH_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result words.
  always_comb begin
    after_nxt      = after_r;
    bank_nxt       = bank_r;
    rc_nxt         = rc_r;
    tc_nxt         = tc_r;
    fill_nxt       = fill_r;
    clean_nxt      = clean_r;
    i_nxt          = i_r;
    ib_nxt         = ib_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    nval_nxt       = nval_r;
    vhold_nxt      = vhold_r;
    hkey_nxt       = hkey_r;
    h_nxt          = h_r;
    rem_nxt        = rem_r;
    mc_nxt         = mc_r;
    rh_nxt         = rh_r;
    j_nxt          = j_r;
    pc_nxt         = pc_r;
    ff_nxt         = ff_r;
    fs_nxt         = fs_r;
    ft_nxt         = ft_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_val_nxt    = res_val_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_val_nxt    = out_val_r;
    out_slot_nxt   = out_slot_r;
    out_live_nxt   = out_live_r;
    rd_bank        = bank_r;
    rd_slot        = j_r;
    kwe            = 1'b0;
    vwe            = 1'b0;
    wr_bank        = bank_r;
    wr_slot        = j_r;
    wr_key         = KEY_EMPTY;
    wr_val         = nval_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FILL_LIMIT:    fill_nxt  = cfg_data;
        REG_CLEANUP_LIMIT: clean_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_INIT: begin
        kwe     = 1'b1;
        wr_bank = ib_r;
        wr_slot = i_r;
        i_nxt   = i_step;
        if (i_last) ib_nxt = 1'b1;
      end
      ST_IDLE: begin
        if (acc) begin
          func_nxt     = func_t'(in_func);
          key_nxt      = in_lookup_key;
          nval_nxt     = in_new_value;
          hkey_nxt     = {1'b0, in_lookup_key};
          rh_nxt       = 1'b0;
          after_nxt    = ST_IDLE;
          res_status_nxt = RS_END;
          res_key_nxt  = '0;
          res_val_nxt  = '0;
          res_slot_nxt = '0;
          if (func_t'(in_func) == FN_CLEAR) begin
            rc_nxt         = '0;
            tc_nxt         = '0;
            res_status_nxt = RS_CLEARED;
            after_nxt      = ST_CLEAR;
            i_nxt          = '0;
          end
          if (func_t'(in_func) == FN_NEXT && start_ok) begin
            j_nxt   = SW'(in_start_slot);
            rd_slot = SW'(in_start_slot);
          end
        end
      end
      ST_HASH1: h_nxt = jenkins_lo(hkey_r);
      ST_HASH2: begin
        h_nxt   = jenkins_hi(h_r);
        rem_nxt = '0;
        mc_nxt  = '0;
      end
      ST_MOD: begin
        rem_nxt = rem_step;
        h_nxt   = h_r << 8;
        mc_nxt  = mc_r + 1'b1;
        if (mod_done) begin
          j_nxt   = home;
          pc_nxt  = '0;
          ff_nxt  = 1'b0;
          ft_nxt  = 1'b0;
          rd_slot = home;
          rd_bank = rh_r ? !bank_r : bank_r;
        end
      end
      ST_PROBE: begin
        if (!pr_done) begin
          j_nxt   = j_step;
          pc_nxt  = pc_r + 1'b1;
          rd_slot = j_step;
          if (k_tomb && !ff_r) begin
            ff_nxt = 1'b1;
            fs_nxt = j_r;
            ft_nxt = 1'b1;
          end
        end else begin
          after_nxt    = ST_IDLE;
          res_key_nxt  = key_r;
          res_slot_nxt = j_r;
          res_val_nxt  = vdata_r;
          if (k_hit) begin
            res_status_nxt = RS_HIT;
            if (func_r == FN_ADD) begin
              vwe            = 1'b1;
              res_status_nxt = RS_REPLACED;
              res_val_nxt    = nval_r;
            end else if (func_r == FN_ERASE) begin
              kwe            = 1'b1;
              wr_key         = KEY_TOMB;
              if (rc_r != '0) rc_nxt = rc_r - 1'b1;
              tc_nxt         = tc_inc;
              res_status_nxt = RS_ERASED;
              if (rh_go) begin
                after_nxt = ST_RH_CLR;
                i_nxt     = '0;
              end
            end
          end else begin
            res_key_nxt  = '0;
            res_val_nxt  = '0;
            res_slot_nxt = '0;
            if (func_r == FN_FIND || func_r == FN_ERASE) begin
              res_status_nxt = RS_ABSENT;
            end else if (full) begin
              res_status_nxt = RS_FULL;
            end else begin
              kwe            = 1'b1;
              vwe            = 1'b1;
              wr_slot        = eff_fs;
              wr_key         = key_ext;
              wr_val         = (func_r == FN_GET) ? VALUE_MINUS_ONE : nval_r;
              rc_nxt         = rc_r + 1'b1;
              if (eff_ft) tc_nxt = tc_r - 1'b1;
              res_status_nxt = RS_INSERTED;
              res_key_nxt    = key_r;
              res_val_nxt    = wr_val;
              res_slot_nxt   = eff_fs;
            end
          end
        end
      end
      ST_SCAN: begin
        after_nxt = ST_IDLE;
        if (k_live) begin
          res_status_nxt = RS_RECORD;
          res_key_nxt    = kdata_r[KEY_W-1:0];
          res_val_nxt    = vdata_r;
          res_slot_nxt   = j_r;
        end else if (j_r != LAST_SLOT) begin
          j_nxt   = j_step;
          rd_slot = j_step;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_val_nxt    = res_val_r;
          out_slot_nxt   = SLOT_OUT_W'(res_slot_r);
          out_live_nxt   = LIVE_W'(rc_r);
        end
      end
      ST_CLEAR: begin
        kwe     = 1'b1;
        wr_slot = i_r;
        i_nxt   = i_step;
      end
      ST_RH_CLR: begin
        kwe     = 1'b1;
        wr_bank = !bank_r;
        wr_slot = i_r;
        i_nxt   = i_step;
      end
      ST_RH_RD: rd_slot = i_r;
      ST_RH_CHK: begin
        if (k_live) begin
          hkey_nxt  = kdata_r;
          vhold_nxt = vdata_r;
          rh_nxt    = 1'b1;
        end else if (i_last) begin
          bank_nxt = !bank_r;
          tc_nxt   = '0;
        end else begin
          i_nxt   = i_step;
          rd_slot = i_step;
        end
      end
      ST_RH_PRB: begin
        if (k_empty) begin
          kwe     = 1'b1;
          vwe     = 1'b1;
          wr_bank = !bank_r;
          wr_key  = hkey_r;
          wr_val  = vhold_r;
          if (i_last) begin
            bank_nxt = !bank_r;
            tc_nxt   = '0;
          end else begin
            i_nxt = i_step;
          end
        end else begin
          j_nxt   = j_step;
          rd_bank = !bank_r;
          rd_slot = j_step;
        end
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (kwe) kmem[wr_bank][wr_slot] <= wr_key;
    if (vwe) vmem[wr_bank][wr_slot] <= wr_val;
    kdata_r <= kmem[rd_bank][rd_slot];
    vdata_r <= vmem[rd_bank][rd_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      after_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      rc_r        <= '0;
      tc_r        <= '0;
      fill_r      <= FILL_RESET;
      clean_r     <= CLEANUP_RESET;
      i_r         <= '0;
      ib_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      bank_r      <= bank_nxt;
      rc_r        <= rc_nxt;
      tc_r        <= tc_nxt;
      fill_r      <= fill_nxt;
      clean_r     <= clean_nxt;
      i_r         <= i_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    nval_r       <= nval_nxt;
    vhold_r      <= vhold_nxt;
    hkey_r       <= hkey_nxt;
    h_r          <= h_nxt;
    rem_r        <= rem_nxt;
    mc_r         <= mc_nxt;
    rh_r         <= rh_nxt;
    j_r          <= j_nxt;
    pc_r         <= pc_nxt;
    ff_r         <= ff_nxt;
    fs_r         <= fs_nxt;
    ft_r         <= ft_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_val_r    <= res_val_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_val_r    <= out_val_nxt;
    out_slot_r   <= out_slot_nxt;
    out_live_r   <= out_live_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;
  assign out_found_slot  = out_slot_r;
  assign out_live_count  = out_live_r;

  // Live plus tombstone slots never exceed the table.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(rc_r) + (CW + 1)'(tc_r)) <= (CW + 1)'(CAPACITY))
    else $error("occupancy exceeds capacity");

  // One operation at a time.
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // A bank swap only ends a rehash and clears the tombstones.
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(bank_r) |-> (tc_r == '0 &&
      ($past(state_r) == ST_RH_CHK || $past(state_r) == ST_RH_PRB)))
    else $error("bank swap outside rehash");

  // No result appears during the reset clearing pass.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !out_valid_r)
    else $error("output during clearing pass");

  // A pending result holds the sequencer in the emit state.
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ready) |=> (state_r == ST_EMIT))
    else $error("result overwritten");

endmodule

FILE: bench/linear_probe_hash_map_tb.sv
// Self-checking bench for linear_probe_hash_map: an internal table predictor works out each
// expected word; a driver and monitor with random idling exercise the valid/ready channels.
// Depends on lph_pkg and the linear_probe_hash_map RTL.
module linear_probe_hash_map_tb;
  import lph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [2:0]         func;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [START_W-1:0] start;
  } op_word_t;

  typedef struct packed {
    logic [3:0]            status;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [SLOT_OUT_W-1:0] slot;
    logic [LIVE_W-1:0]     live;
  } reply_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0, cfg_index = 1'b0;
  logic [2:0] in_func = '0;
  logic [KEY_W-1:0] in_lookup_key = '0;
  logic [VAL_W-1:0] in_new_value = '0;
  logic [START_W-1:0] in_start_slot = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic [3:0] out_status;
  logic [KEY_W-1:0] out_found_key;
  logic [VAL_W-1:0] out_found_value;
  logic [SLOT_OUT_W-1:0] out_found_slot;
  logic [LIVE_W-1:0] out_live_count;

  linear_probe_hash_map #(.CAPACITY(CAP)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: two banks, active bank, counts, limits.
  logic [31:0] tbl_key [2][CAP];
  logic [VAL_W-1:0] tbl_val [2][CAP];
  int unsigned bank, live_n, tomb_n, fill_lim, clean_lim;

  op_word_t    pending_ops[$];
  reply_word_t expected_replies[$];
  int errors = 0, cycles = 0;
  bit calm = 0;
  // Keys recently used, so most operations reuse a known key.
  logic [KEY_W-1:0] key_pool[$];

  function automatic int unsigned hash_home(logic [31:0] x);
    x = (x + 32'h7ed55d16) + (x << 12);
    x = (x ^ 32'hc761c23c) ^ (x >> 19);
    x = (x + 32'h165667b1) + (x << 5);
    x = (x + 32'hd3a2646c) ^ (x << 9);
    x = (x + 32'hfd7046c5) + (x << 3);
    x = (x ^ 32'hb55a4f09) ^ (x >> 16);
    return x % CAP;
  endfunction

  // Walk the probe path; return hit flag, hit slot and first free slot (CAP if none).
  function automatic bit table_probe(logic [31:0] k, output int unsigned hit,
                                     output int unsigned free_at);
    int unsigned j;
    j = hash_home(k);
    free_at = CAP;
    hit = 0;
    for (int n = 0; n < CAP; n++) begin
      if (tbl_key[bank][j] == k) begin
        hit = j;
        return 1;
      end
      if (tbl_key[bank][j] == KEY_EMPTY) begin
        if (free_at == CAP) free_at = j;
        return 0;
      end
      if (tbl_key[bank][j] == KEY_TOMB && free_at == CAP) free_at = j;
      j = (j + 1 == CAP) ? 0 : j + 1;
    end
    return 0;
  endfunction

  function automatic void rebuild_bank();
    int unsigned dst, j;
    dst = bank ^ 1;
    for (int i = 0; i < CAP; i++) tbl_key[dst][i] = KEY_EMPTY;
    for (int i = 0; i < CAP; i++) begin
      if (!tbl_key[bank][i][31]) begin
        j = hash_home(tbl_key[bank][i]);
        for (int n = 0; n < CAP && tbl_key[dst][j] != KEY_EMPTY; n++)
          j = (j + 1 == CAP) ? 0 : j + 1;
        tbl_key[dst][j] = tbl_key[bank][i];
        tbl_val[dst][j] = tbl_val[bank][i];
      end
    end
    bank = dst;
    tomb_n = 0;
  endfunction

  function automatic reply_word_t table_apply(op_word_t op);
    reply_word_t r;
    int unsigned hit, fr, used;
    bit reuse;
    logic [31:0] k;
    r = '0;
    r.status = RS_END;
    k = {1'b0, op.key};
    if (op.func <= FN_ADD_NEW) begin
      if (table_probe(k, hit, fr)) begin
        r.status = RS_HIT;
        if (op.func == FN_ADD) begin
          tbl_val[bank][hit] = op.value;
          r.status = RS_REPLACED;
        end
        r.key = op.key; r.value = tbl_val[bank][hit]; r.slot = SLOT_OUT_W'(hit);
      end else if (op.func == FN_FIND) begin
        r.status = RS_ABSENT;
      end else begin
        reuse = fr < CAP && tbl_key[bank][fr] == KEY_TOMB;
        used = live_n + tomb_n + (reuse ? 0 : 1);
        if (fr >= CAP || used > fill_lim) begin
          r.status = RS_FULL;
        end else begin
          if (reuse) tomb_n--;
          live_n++;
          tbl_key[bank][fr] = k;
          tbl_val[bank][fr] = (op.func == FN_GET) ? VALUE_MINUS_ONE : op.value;
          r.status = RS_INSERTED;
          r.key = op.key; r.value = tbl_val[bank][fr]; r.slot = SLOT_OUT_W'(fr);
        end
      end
    end else if (op.func == FN_ERASE) begin
      if (table_probe(k, hit, fr)) begin
        r.key = op.key; r.value = tbl_val[bank][hit]; r.slot = SLOT_OUT_W'(hit);
        tbl_key[bank][hit] = KEY_TOMB;
        if (live_n > 0) live_n--;
        tomb_n++;
        if (tomb_n >= clean_lim) rebuild_bank();
        r.status = RS_ERASED;
      end else begin
        r.status = RS_ABSENT;
      end
    end else if (op.func == FN_CLEAR) begin
      for (int i = 0; i < CAP; i++) tbl_key[bank][i] = KEY_EMPTY;
      live_n = 0;
      tomb_n = 0;
      r.status = RS_CLEARED;
    end else if (op.func == FN_NEXT) begin
      for (int i = int'(op.start); i < CAP; i++) begin
        if (!tbl_key[bank][i][31]) begin
          r.status = RS_RECORD;
          r.key = tbl_key[bank][i][30:0]; r.value = tbl_val[bank][i];
          r.slot = SLOT_OUT_W'(i);
          break;
        end
      end
    end
    r.live = LIVE_W'(live_n);
    return r;
  endfunction

  // Acceptance seen at the last rising edge; lets the driver know the word is gone.
  logic in_ready_seen = 1'b0;
  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // Driver: advance the input channel at the falling edge, hold while not accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          in_valid      <= 1'b1;
          in_func       <= pending_ops[0].func;
          in_lookup_key <= pending_ops[0].key;
          in_new_value  <= pending_ops[0].value;
          in_start_slot <= pending_ops[0].start;
          expected_replies.push_back(table_apply(pending_ops.pop_front()));
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // Monitor: compare each accepted reply with the oldest expectation.
  always @(posedge clk) begin
    reply_word_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_found_key, out_found_value, out_found_slot, out_live_count};
      if (expected_replies.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected reply %h", got);
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: status %0d/%0d key %h/%h val %h/%h slot %0d/%0d live %0d/%0d",
                     want.status, got.status, want.key, got.key, want.value, got.value,
                     want.slot, got.slot, want.live, got.live);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(99) < 70)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    pick_key = KEY_W'({$urandom, $urandom});
    if ($urandom_range(3) == 0) pick_key = KEY_W'($urandom_range(40));
    key_pool.push_back(pick_key);
    if (key_pool.size() > 60) void'(key_pool.pop_front());
  endfunction

  task automatic queue_op(logic [2:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                          logic [START_W-1:0] s);
    op_word_t op;
    op.func = f; op.key = k; op.value = v; op.start = s;
    pending_ops.push_back(op);
  endtask

  // Wait until all queued words have gone through and replies drained, then settle.
  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (4 * CAP) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FILL_LIMIT) fill_lim = 32'(data); else clean_lim = 32'(data);
  endtask

  task automatic random_phase(int n, int fmax);
    int f;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(99);
      // Mostly inserts and lookups; clears are rare so the table fills up.
      f = f < 25 ? FN_ADD : f < 40 ? FN_ADD_NEW : f < 52 ? FN_GET : f < 70 ? FN_FIND :
          f < 86 ? FN_ERASE : f < 98 ? FN_NEXT : (f == 98 ? FN_CLEAR : fmax);
      queue_op(3'(f), pick_key(), {$urandom, $urandom},
               START_W'(($urandom_range(9) == 0) ? $urandom_range(2047)
                                                 : $urandom_range(CAP - 1)));
    end
  endtask

  initial begin
    bank = 0; live_n = 0; tomb_n = 0;
    fill_lim = 32'(FILL_RESET); clean_lim = 32'(CLEANUP_RESET);
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < CAP; i++) begin
        tbl_key[b][i] = KEY_EMPTY;
        tbl_val[b][i] = '0;
      end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every function, replace, add-if-absent, erase absent, tomb reuse.
    queue_op(FN_FIND, '1, '0, '0);
    queue_op(FN_GET, '1, '0, '0);
    queue_op(FN_GET, '1, '0, '0);
    queue_op(FN_ADD, '0, '1, '0);
    queue_op(FN_ADD, '0, 64'h0123_4567_89ab_cdef, '0);
    queue_op(FN_ADD_NEW, '0, '0, '0);
    queue_op(FN_ADD_NEW, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    queue_op(FN_NEXT, '0, '0, '0);
    queue_op(FN_NEXT, '0, '0, 11'd1023);
    queue_op(FN_NEXT, '0, '0, 11'd1024);
    queue_op(FN_NEXT, '0, '0, 11'h7FF);
    queue_op(FN_ERASE, 31'h2AAA_AAAA, '0, '0);
    queue_op(FN_ERASE, '0, '0, '0);
    queue_op(FN_FIND, '0, '0, '0);
    queue_op(FN_ADD, '0, 64'h5555_5555_5555_5555, '0);
    queue_op(FN_NONE, '1, '1, '1);
    queue_op(FN_CLEAR, '0, '0, '0);
    queue_op(FN_FIND, 31'h5555_5555, '0, '0);
    drain();

    // Tight limits: full refusals and frequent rehash.
    write_reg(REG_FILL_LIMIT, 11'd1);
    write_reg(REG_CLEANUP_LIMIT, 11'd1);
    queue_op(FN_GET, 31'd7, '0, '0);
    queue_op(FN_GET, 31'd8, '0, '0);
    random_phase(100, FN_NONE);
    drain();
    write_reg(REG_FILL_LIMIT, 11'd24);
    write_reg(REG_CLEANUP_LIMIT, 11'd3);
    calm = 1;
    random_phase(150, FN_NONE);
    drain();
    calm = 0;
    write_reg(REG_FILL_LIMIT, 11'h7FF);
    write_reg(REG_CLEANUP_LIMIT, 11'h7FF);
    random_phase(200, FN_NONE);
    drain();
    write_reg(REG_FILL_LIMIT, 11'd1024);
    write_reg(REG_CLEANUP_LIMIT, 11'd1024);
    random_phase(200, FN_CLEAR);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: linear_probe_hash_map.f
design/lph_pkg.sv
design/linear_probe_hash_map.sv
bench/linear_probe_hash_map_tb.sv
